@@ rtl/mtfbls_pkg.sv @@
// Shared types and constants for the move-to-front batch load scheduler.
package mtfbls_pkg;

    localparam int MAX_RESULTS = 64;
    localparam int LIMIT_W = 7;
    localparam logic [LIMIT_W-1:0] BATCH_RESET = 7'd10;

    localparam logic CMD_TOUCH = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_WALK,
        ST_POP_SETUP,
        ST_EMPTY,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic touch;
        logic tick_start;
        logic load;
        logic walk;
        logic pop_setup;
        logic emit_empty;
        logic emit_item;
    } ctl_t;

    typedef struct packed {
        logic bucket_empty;
        logic walk_done;
        logic last_bucket;
        logic pops_zero;
        logic last_pop;
    } stat_t;

endpackage

@@ rtl/mtfbls_ctrl.sv @@
// Sequencer: accepts transactions and steps the drain, search and pop phases.
module mtfbls_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                cmd,
    input  mtfbls_pkg::stat_t   stat,
    output logic                busy,
    output mtfbls_pkg::ctl_t    ctl
);
    import mtfbls_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        busy       = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    if (cmd == CMD_TOUCH)
                    begin
                        ctl.touch = 1'b1;
                    end
                    else
                    begin
                        ctl.tick_start = 1'b1;
                        state_next = stat.bucket_empty ? ST_POP_SETUP : ST_LOAD;
                    end
                end
            end
            ST_LOAD:
            begin
                ctl.load   = 1'b1;
                state_next = ST_WALK;
            end
            ST_WALK:
            begin
                ctl.walk = 1'b1;
                if (stat.walk_done)
                begin
                    state_next = stat.last_bucket ? ST_POP_SETUP : ST_LOAD;
                end
            end
            ST_POP_SETUP:
            begin
                ctl.pop_setup = 1'b1;
                state_next    = stat.pops_zero ? ST_EMPTY : ST_EMIT;
            end
            ST_EMPTY:
            begin
                ctl.emit_empty = 1'b1;
                state_next     = ST_IDLE;
            end
            ST_EMIT:
            begin
                ctl.emit_item = 1'b1;
                if (stat.last_pop)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_walk_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> ($past(state_reg) == ST_LOAD || $past(state_reg) == ST_WALK))
        else $error("walk entered without a bucket load");
    a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(ctl))
        else $error("more than one datapath action at once");
    a_emit_after_setup: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.pop_setup |=> (ctl.emit_empty || ctl.emit_item))
        else $error("pop setup not followed by a result");
`endif

endmodule

@@ rtl/mtfbls_dpath.sv @@
// Datapath: bucket FIFO, circular MTF queue, batch limit register, result registers.
module mtfbls_dpath #(
    parameter int BUCKET_DEPTH = 64,
    parameter int QUEUE_DEPTH  = 64,
    parameter int ID_WIDTH     = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  mtfbls_pkg::ctl_t                  ctl,
    output mtfbls_pkg::stat_t                 stat,
    input  logic                              cfg_we,
    input  logic [mtfbls_pkg::LIMIT_W-1:0]    cfg_wdata,
    input  logic [ID_WIDTH-1:0]               item_id,
    output logic                              result_valid,
    output logic [ID_WIDTH-1:0]               issued_id,
    output logic                              has_item,
    output logic                              last,
    output logic                              running,
    output logic                              dropped
);
    import mtfbls_pkg::*;

    localparam int BAW = $clog2(BUCKET_DEPTH);
    localparam int BCW = $clog2(BUCKET_DEPTH + 1);
    localparam int BW1 = BCW + 1;
    localparam int QAW = $clog2(QUEUE_DEPTH);
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);
    localparam int EW  = QCW + LIMIT_W + 1;

    // storage
    logic [ID_WIDTH-1:0] bucket_mem [BUCKET_DEPTH];
    logic [ID_WIDTH-1:0] queue_mem  [QUEUE_DEPTH];
    logic [ID_WIDTH-1:0] b_rdata_reg;
    logic [ID_WIDTH-1:0] q_rdata_reg;

    // control state
    logic [LIMIT_W-1:0]  batch_limit_reg, batch_limit_next;
    logic [BCW-1:0]      bcount_reg, bcount_next;
    logic [QCW-1:0]      qcount_reg, qcount_next;
    logic [QAW-1:0]      head_reg, head_next;
    logic                active_reg, active_next;
    logic                out_valid_reg, out_valid_next;

    // working registers
    logic [BCW-1:0]      b_reg, b_next;
    logic [QCW-1:0]      idx_reg, idx_next;
    logic [ID_WIDTH-1:0] prev_reg, prev_next;
    logic [LIMIT_W-1:0]  pops_reg, pops_next;
    logic [ID_WIDTH-1:0] out_id_reg, out_id_next;
    logic                out_has_reg, out_has_next;
    logic                out_last_reg, out_last_next;
    logic                out_run_reg, out_run_next;
    logic                out_drop_reg, out_drop_next;

    logic                bucket_full;
    logic                b_we;
    logic                q_we;
    logic [QAW-1:0]      q_waddr;
    logic [QAW-1:0]      q_raddr;
    logic [EW-1:0]       q_rd_off;
    logic [ID_WIDTH-1:0] prev_sel;
    logic                walk_end;
    logic                walk_match;
    logic [LIMIT_W-1:0]  limit_sat;
    logic [EW-1:0]       pops_wide;
    logic [EW-1:0]       qcount_rem;

    function automatic logic [QAW-1:0] wrap_add(input logic [QAW-1:0] base,
                                                input logic [EW-1:0] off);
        logic [EW-1:0] s;
        s = EW'(base) + off;
        if (s >= EW'(QUEUE_DEPTH))
        begin
            s = s - EW'(QUEUE_DEPTH);
        end
        return s[QAW-1:0];
    endfunction

    assign bucket_full = (bcount_reg == BCW'(BUCKET_DEPTH));
    assign b_we        = ctl.touch && !bucket_full;

    assign walk_end   = (idx_reg == qcount_reg);
    assign walk_match = !walk_end && (q_rdata_reg == b_rdata_reg);
    // the first step of a walk carries the drained id itself
    assign prev_sel   = (idx_reg == '0) ? b_rdata_reg : prev_reg;

    assign limit_sat = (batch_limit_reg > LIMIT_W'(MAX_RESULTS)) ?
                       LIMIT_W'(MAX_RESULTS) : batch_limit_reg;
    assign pops_wide = (EW'(qcount_reg) < EW'(limit_sat)) ?
                       EW'(qcount_reg) : EW'(limit_sat);
    assign qcount_rem = EW'(qcount_reg) - EW'(pops_reg);

    assign q_rd_off = (ctl.load || ctl.pop_setup) ? '0 : (EW'(idx_reg) + EW'(1));
    assign q_raddr  = wrap_add(head_reg, q_rd_off);
    assign q_waddr  = wrap_add(head_reg, EW'(idx_reg));
    assign q_we     = ctl.walk && (!walk_end || (qcount_reg != QCW'(QUEUE_DEPTH)));

    always_comb
    begin
        stat.bucket_empty = (bcount_reg == '0);
        stat.walk_done    = walk_end || walk_match;
        stat.last_bucket  = ((BW1'(b_reg) + BW1'(1)) == BW1'(bcount_reg));
        stat.pops_zero    = (pops_wide == '0);
        stat.last_pop     = ((EW'(idx_reg) + EW'(1)) == EW'(pops_reg));
    end

    always_comb
    begin
        batch_limit_next = cfg_we ? cfg_wdata : batch_limit_reg;
        bcount_next      = bcount_reg;
        qcount_next      = qcount_reg;
        head_next        = head_reg;
        active_next      = active_reg;
        out_valid_next   = 1'b0;
        b_next           = b_reg;
        idx_next         = idx_reg;
        prev_next        = prev_reg;
        pops_next        = pops_reg;
        out_id_next      = out_id_reg;
        out_has_next     = out_has_reg;
        out_last_next    = out_last_reg;
        out_run_next     = out_run_reg;
        out_drop_next    = out_drop_reg;

        if (ctl.touch)
        begin
            if (!bucket_full)
            begin
                bcount_next = bcount_reg + BCW'(1);
            end
            active_next    = 1'b1;
            out_valid_next = 1'b1;
            out_id_next    = '0;
            out_has_next   = 1'b0;
            out_last_next  = 1'b1;
            out_run_next   = 1'b1;
            out_drop_next  = bucket_full;
        end

        if (ctl.tick_start)
        begin
            b_next = '0;
        end

        if (ctl.load)
        begin
            idx_next = '0;
        end

        if (ctl.walk)
        begin
            if (walk_end)
            begin
                // not found: grow unless full, in which case the back falls off
                if (qcount_reg != QCW'(QUEUE_DEPTH))
                begin
                    qcount_next = qcount_reg + QCW'(1);
                end
                b_next = b_reg + BCW'(1);
            end
            else if (walk_match)
            begin
                b_next = b_reg + BCW'(1);
            end
            else
            begin
                prev_next = q_rdata_reg;
                idx_next  = idx_reg + QCW'(1);
            end
        end

        if (ctl.pop_setup)
        begin
            bcount_next = '0;
            pops_next   = pops_wide[LIMIT_W-1:0];
            active_next = (EW'(qcount_reg) != pops_wide);
            idx_next    = '0;
        end

        if (ctl.emit_empty)
        begin
            out_valid_next = 1'b1;
            out_id_next    = '0;
            out_has_next   = 1'b0;
            out_last_next  = 1'b1;
            out_run_next   = active_reg;
            out_drop_next  = 1'b0;
        end

        if (ctl.emit_item)
        begin
            out_valid_next = 1'b1;
            out_id_next    = q_rdata_reg;
            out_has_next   = 1'b1;
            out_last_next  = stat.last_pop;
            out_run_next   = active_reg;
            out_drop_next  = 1'b0;
            idx_next       = idx_reg + QCW'(1);
            if (stat.last_pop)
            begin
                head_next   = wrap_add(head_reg, EW'(pops_reg));
                qcount_next = qcount_rem[QCW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            batch_limit_reg <= BATCH_RESET;
            bcount_reg      <= '0;
            qcount_reg      <= '0;
            head_reg        <= '0;
            active_reg      <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            batch_limit_reg <= batch_limit_next;
            bcount_reg      <= bcount_next;
            qcount_reg      <= qcount_next;
            head_reg        <= head_next;
            active_reg      <= active_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b_reg        <= b_next;
        idx_reg      <= idx_next;
        prev_reg     <= prev_next;
        pops_reg     <= pops_next;
        out_id_reg   <= out_id_next;
        out_has_reg  <= out_has_next;
        out_last_reg <= out_last_next;
        out_run_reg  <= out_run_next;
        out_drop_reg <= out_drop_next;
    end

    always_ff @(posedge clk)
    begin
        if (b_we)
        begin
            bucket_mem[bcount_reg[BAW-1:0]] <= item_id;
        end
        b_rdata_reg <= bucket_mem[b_reg[BAW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (q_we)
        begin
            queue_mem[q_waddr] <= prev_sel;
        end
        q_rdata_reg <= queue_mem[q_raddr];
    end

    assign result_valid = out_valid_reg;
    assign issued_id    = out_id_reg;
    assign has_item     = out_has_reg;
    assign last         = out_last_reg;
    assign running      = out_run_reg;
    assign dropped      = out_drop_reg;

`ifndef ASSERT_OFF
    a_bcount_range: assert property (@(posedge clk) disable iff (!rst_n)
        bcount_reg <= BCW'(BUCKET_DEPTH))
        else $error("bucket count beyond depth");
    a_qcount_range: assert property (@(posedge clk) disable iff (!rst_n)
        qcount_reg <= QCW'(QUEUE_DEPTH))
        else $error("queue count beyond depth");
    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_has_reg) |-> out_last_reg)
        else $error("empty result not marked last");
    a_drop_on_touch: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_drop_reg) |-> (!out_has_reg && out_run_reg))
        else $error("drop flag outside a touch result");
    a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.emit_item && stat.last_pop) |=> (qcount_reg <= $past(qcount_reg)))
        else $error("queue grew on pop");
`endif

endmodule

@@ rtl/mtf_batch_load_scheduler.sv @@
// Latency: a touch gives its one result in the cycle after acceptance; busy stays low.
// A tick loads each drained id and walks it down the queue, one entry a cycle, then passes
// a pop setup state and emits the popped ids, or one empty result if none popped.
// Throughput: touches one per cycle while busy is low; a tick is bound by the single queue memory.
// Reset: rst_n asynchronous, empties bucket and queue, clears active_reg, limit back to 10.
// Results appear for one cycle on result_valid; the receiver cannot stall them.
module mtf_batch_load_scheduler #(
    parameter int BUCKET_DEPTH = 64,
    parameter int QUEUE_DEPTH  = 64,
    parameter int ID_WIDTH     = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              cmd,
    input  logic [ID_WIDTH-1:0]               item_id,
    input  logic                              cfg_we,
    input  logic [mtfbls_pkg::LIMIT_W-1:0]    cfg_wdata,
    output logic                              result_valid,
    output logic [ID_WIDTH-1:0]               issued_id,
    output logic                              has_item,
    output logic                              last,
    output logic                              running,
    output logic                              dropped
);
    import mtfbls_pkg::*;

    ctl_t  ctl;
    stat_t stat;

    mtfbls_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .stat  (stat),
        .busy  (busy),
        .ctl   (ctl)
    );

    mtfbls_dpath #(
        .BUCKET_DEPTH (BUCKET_DEPTH),
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .ID_WIDTH     (ID_WIDTH)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .stat         (stat),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .item_id      (item_id),
        .result_valid (result_valid),
        .issued_id    (issued_id),
        .has_item     (has_item),
        .last         (last),
        .running      (running),
        .dropped      (dropped)
    );

endmodule
